### design/ccdik_pkg.sv
// Shared types, constants and the arctangent table of the CCD arm solver.
package ccdik_pkg;

  localparam int MAX_LIMBS_DEF     = 8;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int TAB_LEN           = 24;
  localparam logic signed [35:0] GAIN_Q28 = 36'sd163008219;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_SOLVE  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [0:0] CFG_TOLERANCE = 1'b0;
  localparam logic [0:0] CFG_MAX_STEPS = 1'b1;

  typedef struct packed {
    logic [1:0]         mode;
    logic [26:0]        limb_length;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         limb_index;
    logic signed [31:0] head_x;
    logic signed [31:0] head_y;
    logic signed [15:0] joint_rotation;
    logic               reached;
    logic [15:0]        steps_used;
    logic               last;
  } out_beat_t;

  typedef enum logic [1:0] {
    CM_VEC,
    CM_ROT
  } cordic_mode_t;

  typedef struct packed {
    logic         go;
    cordic_mode_t mode;
  } cordic_cmd_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0:  r = 32'h20000000;
        5'd1:  r = 32'h12E4051E;
        5'd2:  r = 32'h09FB385B;
        5'd3:  r = 32'h051111D4;
        5'd4:  r = 32'h028B0D43;
        5'd5:  r = 32'h0145D7E1;
        5'd6:  r = 32'h00A2F61E;
        5'd7:  r = 32'h00517C55;
        5'd8:  r = 32'h0028BE53;
        5'd9:  r = 32'h00145F2F;
        5'd10: r = 32'h000A2F98;
        5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6;
        5'd13: r = 32'h000145F3;
        5'd14: r = 32'h0000A2FA;
        5'd15: r = 32'h0000517D;
        5'd16: r = 32'h000028BE;
        5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A30;
        5'd19: r = 32'h00000518;
        5'd20: r = 32'h0000028C;
        5'd21: r = 32'h00000146;
        5'd22: r = 32'h000000A3;
        5'd23: r = 32'h00000051;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_APPEND,
    ST_CLEAR,
    ST_TEST,
    ST_LOADJ,
    ST_VEC_G,
    ST_VEC_G_W,
    ST_VEC_E,
    ST_VEC_E_W,
    ST_ROT,
    ST_ROT_W,
    ST_PT_LOAD,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_MUL_D,
    ST_PT_STORE,
    ST_ADVANCE,
    ST_EMIT
  } state_t;

endpackage

### design/ccdik_cordic.sv
// Iterative CORDIC unit: vectoring gives an angle, rotation gives cos and sin.
module ccdik_cordic #(
  parameter int CORDIC_STAGES = ccdik_pkg::CORDIC_STAGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ccdik_pkg::cordic_cmd_t cmd,
  input  logic signed [35:0]    vec_x,
  input  logic signed [35:0]    vec_y,
  input  logic [15:0]           rot_angle,
  output logic                  done,
  output logic [31:0]           angle,
  output logic signed [35:0]    cos_q28,
  output logic signed [35:0]    sin_q28
);

  localparam int NSTEP = (CORDIC_STAGES < ccdik_pkg::TAB_LEN) ? CORDIC_STAGES
                                                              : ccdik_pkg::TAB_LEN;

  // Vectoring inputs stay below 2^34 in magnitude, so 38 bits hold the growth.
  logic signed [37:0] x_r, y_r;
  logic signed [32:0] z_r;
  logic [4:0]         i_r;
  logic               busy_r;
  logic               vec_r;
  logic               done_r;

  logic signed [37:0] xs, ys;
  logic signed [32:0] at;
  logic               dir_up;
  logic signed [32:0] z0;

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign at = $signed({1'b0, ccdik_pkg::atan_entry(i_r)});
  assign dir_up = vec_r ? (y_r > 0) : (z_r < 0);
  assign z0 = $signed({rot_angle[15], rot_angle, 16'h0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.go) begin
        busy_r <= 1'b1;
        i_r    <= '0;
        vec_r  <= (cmd.mode == ccdik_pkg::CM_VEC);
        if (cmd.mode == ccdik_pkg::CM_VEC) begin
          if (vec_x < 0) begin
            x_r <= 38'(-vec_x);
            y_r <= 38'(-vec_y);
            z_r <= 33'sh080000000;
          end else begin
            x_r <= 38'(vec_x);
            y_r <= 38'(vec_y);
            z_r <= '0;
          end
        end else begin
          y_r <= '0;
          if (z0 > 33'sh040000000) begin
            x_r <= 38'(-ccdik_pkg::GAIN_Q28);
            z_r <= z0 - 33'sh080000000;
          end else if (z0 < -33'sh040000000) begin
            x_r <= 38'(-ccdik_pkg::GAIN_Q28);
            z_r <= z0 + 33'sh080000000;
          end else begin
            x_r <= 38'(ccdik_pkg::GAIN_Q28);
            z_r <= z0;
          end
        end
      end else if (busy_r) begin
        // Vectoring: y>0 means turn down. Rotation: z>=0 means turn up.
        if (vec_r ? dir_up : !dir_up) begin
          x_r <= vec_r ? x_r + ys : x_r - ys;
          y_r <= vec_r ? y_r - xs : y_r + xs;
          z_r <= vec_r ? z_r + at : z_r - at;
        end else begin
          x_r <= vec_r ? x_r - ys : x_r + ys;
          y_r <= vec_r ? y_r + xs : y_r - xs;
          z_r <= vec_r ? z_r - at : z_r + at;
        end
        i_r <= i_r + 5'd1;
        if (32'(i_r) == NSTEP - 1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done    = done_r;
  assign angle   = z_r[31:0];
  assign cos_q28 = x_r[35:0];
  assign sin_q28 = y_r[35:0];

endmodule

### design/planar_ccd_inverse_kinematics_top.sv
// Top level of the planar CCD inverse kinematics solver: sequencer and arm state.
//
// A user issues one command per beat with start while busy is low. Mode 0
// appends a limb along x from the current head (ignored on a full arm), mode 2
// clears the arm, mode 1 solves toward the target and then sends one result
// beat per limb, base first, each marked by out_valid for exactly one cycle;
// the receiver cannot stall these beats, so it must take every one. Append
// and clear keep busy high for one cycle. A solve sends L result beats, L
// being the limb count, after its joint steps: every step runs the one
// shared CORDIC unit for two vectoring angles and, unless the rotation is
// skipped, once more for cos/sin, and rotates each head that it moves (at
// most L) through one shared 36x33 multiplier, four products per head. A step
// whose effector or target sits on the joint skips the rotation. By default
// a solve stops after at most 1024 steps. Configuration writes of tolerance
// and max_steps act at once, so they belong only in cycles where busy is low.
module planar_ccd_inverse_kinematics_top #(
  parameter int MAX_LIMBS     = ccdik_pkg::MAX_LIMBS_DEF,
  parameter int CORDIC_STAGES = ccdik_pkg::CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  ccdik_pkg::in_beat_t  in_beat,
  output logic                 out_valid,
  output ccdik_pkg::out_beat_t out_beat,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_wdata
);

  localparam int IW = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;
  localparam int CW = $clog2(MAX_LIMBS + 1);

  // Arm state held in flip-flops; each entry sits behind a small mux.
  logic signed [31:0] hx_r [MAX_LIMBS];
  logic signed [31:0] hy_r [MAX_LIMBS];
  logic [15:0]        ang_r [MAX_LIMBS];
  logic [CW-1:0]      total_r;
  logic [IW-1:0]      joint_r;
  logic [15:0]        steps_r;
  logic [15:0]        tol_r, maxs_r;

  ccdik_pkg::state_t  state_r, state_nxt;
  ccdik_pkg::in_beat_t cmd_r;
  logic [IW-1:0]      k_r;
  logic signed [31:0] jx_r, jy_r;
  logic [31:0]        ag_r;
  logic [15:0]        th_r;
  logic signed [35:0] c_r, s_r;
  logic signed [32:0] dx_r, dy_r;
  logic signed [68:0] acc_r;
  logic signed [63:0] nx_r;
  logic               hit_r;

  logic [IW-1:0]      e_idx;
  logic signed [31:0] ex_end, ey_end;
  logic signed [32:0] dtx, dty;
  logic               in_tol;

  ccdik_pkg::cordic_cmd_t ccmd;
  logic signed [35:0] cvx, cvy;
  logic               cdone;
  logic [31:0]        cang;
  logic signed [35:0] ccos, csin;

  logic signed [35:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [68:0] prod;
  logic signed [68:0] rnd;
  logic signed [31:0] sat_new;

  ccdik_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk(clk), .rst_n(rst_n), .cmd(ccmd), .vec_x(cvx), .vec_y(cvy),
    .rot_angle(th_r), .done(cdone), .angle(cang), .cos_q28(ccos), .sin_q28(csin)
  );

  assign e_idx  = IW'(total_r - CW'(1));
  assign ex_end = hx_r[e_idx];
  assign ey_end = hy_r[e_idx];
  assign dtx    = 33'(ex_end) - 33'(cmd_r.target_x);
  assign dty    = 33'(ey_end) - 33'(cmd_r.target_y);
  // |d| < tol, tested as -tol < d < tol.
  assign in_tol = (dtx < $signed({17'd0, tol_r})) && (dtx > -$signed({17'd0, tol_r})) &&
                  (dty < $signed({17'd0, tol_r})) && (dty > -$signed({17'd0, tol_r}));

  // The shared multiplier: the sequencer picks one product per cycle.
  always_comb begin
    mul_a = c_r;
    mul_b = dx_r;
    unique case (state_r)
      ccdik_pkg::ST_MUL_A: begin mul_a = c_r; mul_b = dx_r; end
      ccdik_pkg::ST_MUL_B: begin mul_a = -s_r; mul_b = dy_r; end
      ccdik_pkg::ST_MUL_C: begin mul_a = s_r; mul_b = dx_r; end
      ccdik_pkg::ST_MUL_D: begin mul_a = c_r; mul_b = dy_r; end
      default: ;
    endcase
  end
  assign prod = 69'(mul_a) * 69'(mul_b);
  // acc_r holds the finished sum; round half up at bit 28.
  assign rnd  = (acc_r + 69'sd134217728) >>> 28;

  always_comb begin
    logic signed [33:0] s34;
    s34 = 34'(rnd) + 34'(state_r == ccdik_pkg::ST_MUL_C ? jx_r : jy_r);
    if (s34 > 34'sd2147483647)       sat_new = 32'sh7FFFFFFF;
    else if (s34 < -34'sd2147483648) sat_new = 32'sh80000000;
    else                             sat_new = s34[31:0];
  end

  // Vectoring operand: target vector first, then effector vector.
  always_comb begin
    ccmd.go   = 1'b0;
    ccmd.mode = ccdik_pkg::CM_VEC;
    cvx = 36'(cmd_r.target_x) - 36'(jx_r);
    cvy = 36'(cmd_r.target_y) - 36'(jy_r);
    unique case (state_r)
      ccdik_pkg::ST_VEC_G: ccmd.go = 1'b1;
      ccdik_pkg::ST_VEC_E: begin
        ccmd.go = 1'b1;
        cvx = 36'(ex_end) - 36'(jx_r);
        cvy = 36'(ey_end) - 36'(jy_r);
      end
      ccdik_pkg::ST_ROT: begin
        ccmd.go = 1'b1;
        ccmd.mode = ccdik_pkg::CM_ROT;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ccdik_pkg::ST_IDLE:
        if (start) begin
          unique case (in_beat.mode)
            ccdik_pkg::MODE_APPEND: state_nxt = ccdik_pkg::ST_APPEND;
            ccdik_pkg::MODE_CLEAR:  state_nxt = ccdik_pkg::ST_CLEAR;
            ccdik_pkg::MODE_SOLVE:  state_nxt = ccdik_pkg::ST_TEST;
            default:                state_nxt = ccdik_pkg::ST_IDLE;
          endcase
        end
      ccdik_pkg::ST_APPEND, ccdik_pkg::ST_CLEAR: state_nxt = ccdik_pkg::ST_IDLE;
      ccdik_pkg::ST_TEST:
        if (total_r == '0)                          state_nxt = ccdik_pkg::ST_IDLE;
        else if ((in_tol && tol_r != '0) || steps_r >= maxs_r)
                                                    state_nxt = ccdik_pkg::ST_EMIT;
        else                                        state_nxt = ccdik_pkg::ST_LOADJ;
      ccdik_pkg::ST_LOADJ:   state_nxt = ccdik_pkg::ST_VEC_G;
      ccdik_pkg::ST_VEC_G:   state_nxt = ccdik_pkg::ST_VEC_G_W;
      ccdik_pkg::ST_VEC_G_W: if (cdone) state_nxt = ccdik_pkg::ST_VEC_E;
      ccdik_pkg::ST_VEC_E:   state_nxt = ccdik_pkg::ST_VEC_E_W;
      ccdik_pkg::ST_VEC_E_W:
        if (cdone) begin
          if ((ex_end == jx_r && ey_end == jy_r) ||
              (cmd_r.target_x == jx_r && cmd_r.target_y == jy_r))
            state_nxt = ccdik_pkg::ST_ADVANCE;
          else
            state_nxt = ccdik_pkg::ST_ROT;
        end
      ccdik_pkg::ST_ROT:      state_nxt = ccdik_pkg::ST_ROT_W;
      ccdik_pkg::ST_ROT_W:    if (cdone) state_nxt = ccdik_pkg::ST_PT_LOAD;
      ccdik_pkg::ST_PT_LOAD:  state_nxt = ccdik_pkg::ST_MUL_A;
      ccdik_pkg::ST_MUL_A:    state_nxt = ccdik_pkg::ST_MUL_B;
      ccdik_pkg::ST_MUL_B:    state_nxt = ccdik_pkg::ST_MUL_C;
      ccdik_pkg::ST_MUL_C:    state_nxt = ccdik_pkg::ST_MUL_D;
      ccdik_pkg::ST_MUL_D:    state_nxt = ccdik_pkg::ST_PT_STORE;
      ccdik_pkg::ST_PT_STORE:
        if (CW'(k_r) + CW'(1) >= total_r) state_nxt = ccdik_pkg::ST_ADVANCE;
        else                              state_nxt = ccdik_pkg::ST_PT_LOAD;
      ccdik_pkg::ST_ADVANCE: state_nxt = ccdik_pkg::ST_TEST;
      ccdik_pkg::ST_EMIT:
        if (CW'(k_r) + CW'(1) >= total_r) state_nxt = ccdik_pkg::ST_IDLE;
        else                              state_nxt = ccdik_pkg::ST_EMIT;
      default: state_nxt = ccdik_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ccdik_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      joint_r <= '0;
      steps_r <= '0;
      tol_r   <= 16'd655;
      maxs_r  <= 16'd1024;
      for (int i = 0; i < MAX_LIMBS; i++) begin
        hx_r[i] <= '0; hy_r[i] <= '0; ang_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == ccdik_pkg::CFG_TOLERANCE) tol_r  <= cfg_wdata;
        else                                       maxs_r <= cfg_wdata;
      end
      unique case (state_r)
        ccdik_pkg::ST_IDLE:
          if (start) begin
            cmd_r <= in_beat;
            k_r   <= '0;
          end
        ccdik_pkg::ST_APPEND:
          if (total_r < CW'(MAX_LIMBS)) begin
            logic signed [33:0] ax;
            ax = (total_r == '0) ? 34'(cmd_r.limb_length)
                 : 34'(ex_end) + 34'(cmd_r.limb_length);
            hx_r[IW'(total_r)]  <= (ax > 34'sd2147483647) ? 32'sh7FFFFFFF : ax[31:0];
            hy_r[IW'(total_r)]  <= (total_r == '0) ? 32'sd0 : ey_end;
            ang_r[IW'(total_r)] <= '0;
            total_r <= total_r + CW'(1);
          end
        ccdik_pkg::ST_CLEAR: begin
          total_r <= '0;
          joint_r <= '0;
          steps_r <= '0;
          for (int i = 0; i < MAX_LIMBS; i++) begin
            hx_r[i] <= '0; hy_r[i] <= '0; ang_r[i] <= '0;
          end
        end
        ccdik_pkg::ST_TEST: begin
          hit_r <= in_tol && tol_r != '0;
        end
        ccdik_pkg::ST_LOADJ: begin
          jx_r <= (joint_r == '0) ? 32'sd0 : hx_r[joint_r - IW'(1)];
          jy_r <= (joint_r == '0) ? 32'sd0 : hy_r[joint_r - IW'(1)];
        end
        ccdik_pkg::ST_VEC_G_W: if (cdone) ag_r <= cang;
        ccdik_pkg::ST_VEC_E_W:
          if (cdone) begin
            logic [31:0] r;
            r = (ag_r - cang) + 32'h8000;
            th_r <= r[31:16];
            k_r  <= joint_r;
          end
        ccdik_pkg::ST_ROT_W:
          if (cdone) begin
            c_r <= ccos;
            s_r <= csin;
            ang_r[joint_r] <= ang_r[joint_r] + th_r;
          end
        ccdik_pkg::ST_PT_LOAD: begin
          dx_r <= 33'(hx_r[k_r]) - 33'(jx_r);
          dy_r <= 33'(hy_r[k_r]) - 33'(jy_r);
        end
        ccdik_pkg::ST_MUL_A: acc_r <= prod;
        ccdik_pkg::ST_MUL_B: begin
          acc_r <= acc_r + prod;
        end
        ccdik_pkg::ST_MUL_C: begin
          nx_r  <= 64'(sat_new);
          acc_r <= prod;
        end
        ccdik_pkg::ST_MUL_D: acc_r <= acc_r + prod;
        ccdik_pkg::ST_PT_STORE: begin
          hx_r[k_r] <= nx_r[31:0];
          hy_r[k_r] <= sat_new;
          k_r <= k_r + IW'(1);
        end
        ccdik_pkg::ST_ADVANCE: begin
          steps_r <= steps_r + 16'd1;
          joint_r <= (joint_r == '0) ? e_idx : joint_r - IW'(1);
          k_r     <= '0;
        end
        ccdik_pkg::ST_EMIT: k_r <= k_r + IW'(1);
        default: ;
      endcase
      // A solve command on a non-empty arm resets joint and steps before its first test.
      if (state_r == ccdik_pkg::ST_IDLE && start && in_beat.mode == ccdik_pkg::MODE_SOLVE
          && total_r != '0) begin
        joint_r <= e_idx;
        steps_r <= '0;
      end
    end
  end

  assign busy      = (state_r != ccdik_pkg::ST_IDLE);
  assign out_valid = (state_r == ccdik_pkg::ST_EMIT);

  always_comb begin
    out_beat.limb_index     = 3'(k_r);
    out_beat.head_x         = hx_r[k_r];
    out_beat.head_y         = hy_r[k_r];
    out_beat.joint_rotation = ang_r[k_r];
    out_beat.reached        = hit_r;
    out_beat.steps_used     = steps_r;
    out_beat.last           = (CW'(k_r) + CW'(1) >= total_r);
  end

endmodule

### tb/tb_top.sv
// Self-checking testbench for the planar CCD inverse kinematics solver.
module tb_top;

  // The scoreboard keeps its own copy of the arm and of the two registers.
  // Each accepted command runs through the same fixed-point solve as the
  // block, and every limb beat that a solve should produce is queued here.
  class ccd_arm_scoreboard;
    longint     head_x[8];
    longint     head_y[8];
    logic [15:0] joint_ang[8];
    int unsigned limb_count;
    int unsigned joint_sel;
    int unsigned step_cnt;
    int unsigned tol;
    int unsigned step_limit;
    ccdik_pkg::out_beat_t limb_expect_q[$];
    int         mismatches;

    function new();
      foreach (head_x[i]) begin
        head_x[i] = 0;
        head_y[i] = 0;
        joint_ang[i] = '0;
      end
      limb_count = 0;
      joint_sel = 0;
      step_cnt = 0;
      tol = 655;
      step_limit = 1024;
      mismatches = 0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [15:0] val);
      if (idx == ccdik_pkg::CFG_TOLERANCE) tol = val;
      else step_limit = val;
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint absv(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function logic [31:0] atan_val(int i);
      logic [31:0] t[16];
      t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
            32'h0000517D};
      return t[i];
    endfunction

    // Vectoring CORDIC: angle of (x, y) as a 32-bit binary angle.
    function logic [31:0] vec_angle(longint x, longint y);
      logic [31:0] z;
      longint xs, ys;
      z = '0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h80000000;
      end
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_val(i);
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atan_val(i);
        end
      end
      return z;
    endfunction

    // Rotation CORDIC: cos and sin in Q4.28, gain already folded in.
    function void cos_sin(logic [15:0] a, output longint c, output longint s);
      longint z, x, y, xs, ys;
      z = longint'({a, 16'h0000});
      x = 163008219;
      y = 0;
      if (z >= 64'sh80000000) z = z - 64'sh100000000;
      if (z > 64'sh40000000) begin
        x = -x;
        z = z - 64'sh80000000;
      end else if (z < -64'sh40000000) begin
        x = -x;
        z = z + 64'sh80000000;
      end
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - longint'(atan_val(i));
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + longint'(atan_val(i));
        end
      end
      c = x;
      s = y;
    endfunction

    function bit near_target(longint tx, longint ty);
      int unsigned e;
      e = limb_count - 1;
      return absv(head_x[e] - tx) < longint'(tol) && absv(head_y[e] - ty) < longint'(tol);
    endfunction

    // One joint update: turn the selected joint so the effector points at the target.
    function void joint_update(longint tx, longint ty);
      int unsigned j, e;
      longint jx, jy, ex, ey, gx, gy, c, s, dx, dy, nx, ny;
      logic [31:0] d, dr;
      logic [15:0] th;
      j = joint_sel;
      e = limb_count - 1;
      jx = 0;
      jy = 0;
      if (j > e) j = e;
      if (j > 0) begin
        jx = head_x[j-1];
        jy = head_y[j-1];
      end
      ex = head_x[e] - jx;
      ey = head_y[e] - jy;
      gx = tx - jx;
      gy = ty - jy;
      // A zero-length vector on either side leaves the arm untouched.
      if ((ex != 0 || ey != 0) && (gx != 0 || gy != 0)) begin
        d = vec_angle(gx, gy) - vec_angle(ex, ey);
        dr = d + 32'h8000;
        th = dr[31:16];
        cos_sin(th, c, s);
        joint_ang[j] = joint_ang[j] + th;
        for (int unsigned k = j; k < limb_count; k++) begin
          dx = head_x[k] - jx;
          dy = head_y[k] - jy;
          nx = (dx * c - dy * s + (64'sd1 <<< 27)) >>> 28;
          ny = (dx * s + dy * c + (64'sd1 <<< 27)) >>> 28;
          head_x[k] = sat32(jx + nx);
          head_y[k] = sat32(jy + ny);
        end
      end
      step_cnt = (step_cnt + 1) & 16'hFFFF;
      joint_sel = (j == 0) ? e : j - 1;
    endfunction

    function void note_command(ccdik_pkg::in_beat_t cmd);
      longint tx, ty, base_x, base_y;
      bit hit;
      ccdik_pkg::out_beat_t ob;
      if (cmd.mode == ccdik_pkg::MODE_APPEND) begin
        if (limb_count < 8) begin
          base_x = 0;
          base_y = 0;
          if (limb_count > 0) begin
            base_x = head_x[limb_count-1];
            base_y = head_y[limb_count-1];
          end
          head_x[limb_count] = sat32(base_x + longint'(cmd.limb_length));
          head_y[limb_count] = base_y;
          joint_ang[limb_count] = '0;
          limb_count++;
        end
      end else if (cmd.mode == ccdik_pkg::MODE_CLEAR) begin
        foreach (head_x[i]) begin
          head_x[i] = 0;
          head_y[i] = 0;
          joint_ang[i] = '0;
        end
        limb_count = 0;
        joint_sel = 0;
        step_cnt = 0;
      end else if (cmd.mode == ccdik_pkg::MODE_SOLVE && limb_count > 0) begin
        tx = longint'(cmd.target_x);
        ty = longint'(cmd.target_y);
        joint_sel = limb_count - 1;
        step_cnt = 0;
        while (1) begin
          hit = near_target(tx, ty);
          if (hit || step_cnt >= step_limit) break;
          joint_update(tx, ty);
        end
        for (int unsigned k = 0; k < limb_count; k++) begin
          ob.limb_index = k[2:0];
          ob.head_x = head_x[k][31:0];
          ob.head_y = head_y[k][31:0];
          ob.joint_rotation = joint_ang[k];
          ob.reached = hit;
          ob.steps_used = step_cnt[15:0];
          ob.last = (k + 1 == limb_count);
          limb_expect_q.push_back(ob);
        end
      end
    endfunction

    function void report(string what, ccdik_pkg::out_beat_t exp_b,
                         ccdik_pkg::out_beat_t got_b);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch (%s): expected %p, got %p", what, exp_b, got_b);
    endfunction

    function void check_limb(ccdik_pkg::out_beat_t got_b);
      ccdik_pkg::out_beat_t exp_b;
      if (limb_expect_q.size() == 0) begin
        exp_b = '0;
        report("unexpected beat", exp_b, got_b);
        return;
      end
      exp_b = limb_expect_q.pop_front();
      if (got_b.limb_index !== exp_b.limb_index) report("limb_index", exp_b, got_b);
      else if (got_b.head_x !== exp_b.head_x) report("head_x", exp_b, got_b);
      else if (got_b.head_y !== exp_b.head_y) report("head_y", exp_b, got_b);
      else if (got_b.joint_rotation !== exp_b.joint_rotation)
        report("joint_rotation", exp_b, got_b);
      else if (got_b.reached !== exp_b.reached) report("reached", exp_b, got_b);
      else if (got_b.steps_used !== exp_b.steps_used) report("steps_used", exp_b, got_b);
      else if (got_b.last !== exp_b.last) report("last", exp_b, got_b);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  ccdik_pkg::in_beat_t in_beat = '0;
  logic        out_valid;
  ccdik_pkg::out_beat_t out_beat;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = ccdik_pkg::CFG_TOLERANCE;
  logic [15:0] cfg_wdata = '0;

  ccd_arm_scoreboard arm_sb = new();
  int          gap_pct;
  int          beats_sent;

  planar_ccd_inverse_kinematics_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_beat  (out_beat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Result beats cannot be stalled, so every strobed cycle is checked as it goes by.
  // Values read right after the edge are the ones the edge sampled.
  always @(posedge clk) begin
    if (rst_n && out_valid) arm_sb.check_limb(out_beat);
  end

  // Hold a command on the port until the block takes it. The caller either
  // sends the next beat at once, which keeps start high, or idles.
  task automatic send_cmd(ccdik_pkg::in_beat_t cmd);
    start <= 1'b1;
    in_beat <= cmd;
    do @(posedge clk); while (busy);
    arm_sb.note_command(cmd);
    beats_sent++;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic send_mode(logic [1:0] m, logic [26:0] len, logic [31:0] tx,
                           logic [31:0] ty);
    ccdik_pkg::in_beat_t cmd;
    cmd.mode = m;
    cmd.limb_length = len;
    cmd.target_x = tx;
    cmd.target_y = ty;
    send_cmd(cmd);
  endtask

  // Wait for the block to drain. Appends and clears give no result, so the
  // wait also holds until busy is low.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (arm_sb.limb_expect_q.size() != 0 || busy);
    repeat (8) @(posedge clk);
  endtask

  // One register write; the enable drops again at the next edge, so writes in a row
  // never drive the enable twice at the same instant.
  task automatic write_cfg(logic [0:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    arm_sb.write_reg(idx, val);
  endtask

  function automatic logic [26:0] rand_len();
    int r;
    r = $urandom_range(99);
    if (r < 80) return 27'($urandom_range(0, 20 * 65536));
    if (r < 90) return 27'($urandom);
    return (r < 95) ? 27'h7FFFFFF : 27'h0;
  endfunction

  // Targets mostly within reach of the arm, now and then anywhere at all.
  function automatic logic [31:0] rand_coord(int reach);
    if ($urandom_range(99) < 85)
      return 32'($signed($urandom_range(0, 2 * reach)) - reach);
    return $urandom;
  endfunction

  task automatic random_part(int count);
    int nl, ns, reach;
    while (beats_sent < count) begin
      if ($urandom_range(99) < 75) begin
        // Well-formed sequence: fresh arm, a few limbs, then a few solves.
        send_mode(ccdik_pkg::MODE_CLEAR, rand_len(), $urandom, $urandom);
        nl = $urandom_range(1, 8);
        reach = 0;
        for (int i = 0; i < nl; i++) begin
          send_mode(ccdik_pkg::MODE_APPEND, 27'($urandom_range(0, 8 * 65536)),
                    $urandom, $urandom);
        end
        reach = (arm_sb.limb_count > 0) ? int'(arm_sb.head_x[arm_sb.limb_count-1]) : 0;
        if (reach < 65536) reach = 65536;
        ns = $urandom_range(1, 3);
        for (int i = 0; i < ns; i++) begin
          send_mode(ccdik_pkg::MODE_SOLVE, rand_len(), rand_coord(reach),
                    rand_coord(reach));
        end
      end else begin
        // Noise: any mode, any field values, including the unused mode.
        send_mode(2'($urandom_range(0, 3)), rand_len(), $urandom, $urandom);
      end
    end
  endtask

  initial begin
    longint ex, ey;
    gap_pct = 0;
    beats_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with the reset settings.
    send_mode(ccdik_pkg::MODE_SOLVE, '0, 32'sd65536, 32'sd0);  // empty arm: no beats
    send_mode(2'd3, 27'h7FFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);  // unused mode
    send_mode(ccdik_pkg::MODE_APPEND, 27'h0, '0, '0);           // zero-length limb
    send_mode(ccdik_pkg::MODE_APPEND, 27'd131072, '0, '0);
    send_mode(ccdik_pkg::MODE_SOLVE, '0, 32'sd0, 32'sd0);   // target on the base joint
    send_mode(ccdik_pkg::MODE_SOLVE, '0, 32'sd65536, 32'sd65536);
    send_mode(ccdik_pkg::MODE_SOLVE, '0, 32'h80000000, 32'h7FFFFFFF); // unreachable corner
    send_mode(ccdik_pkg::MODE_CLEAR, '0, '0, '0);
    for (int i = 0; i < 8; i++)
      send_mode(ccdik_pkg::MODE_APPEND, 27'd65536 + 27'(i), '0, '0);
    send_mode(ccdik_pkg::MODE_APPEND, 27'h7FFFFFF, '0, '0);  // arm full: ignored
    send_mode(ccdik_pkg::MODE_SOLVE, '0, 32'sd200000, -32'sd300000);
    send_mode(ccdik_pkg::MODE_SOLVE, '0, -32'sd400000, 32'sd100000);
    send_mode(ccdik_pkg::MODE_CLEAR, '0, '0, '0);
    send_mode(ccdik_pkg::MODE_APPEND, 27'h7FFFFFF, '0, '0);  // longest limb
    send_mode(ccdik_pkg::MODE_SOLVE, '0, 32'h7FFFFFFF, 32'h80000000);
    drain();

    // Widest settings: only solves that end at once, since a miss could run
    // through all 65535 steps. Targets sit just off the effector.
    write_cfg(ccdik_pkg::CFG_TOLERANCE, 16'hFFFF);
    write_cfg(ccdik_pkg::CFG_MAX_STEPS, 16'hFFFF);
    for (int i = 0; i < 3; i++) begin
      ex = arm_sb.head_x[arm_sb.limb_count-1];
      ey = arm_sb.head_y[arm_sb.limb_count-1];
      send_mode(ccdik_pkg::MODE_SOLVE, '0, 32'(ex + $urandom_range(0, 60000)),
                32'(ey - $urandom_range(0, 60000)));
    end
    drain();

    // Tightest settings: zero tolerance never reaches, one step per solve.
    write_cfg(ccdik_pkg::CFG_TOLERANCE, 16'h0);
    write_cfg(ccdik_pkg::CFG_MAX_STEPS, 16'h1);
    gap_pct = 20;
    beats_sent = 0;
    random_part(100);
    drain();

    // Everyday settings with the sender idling more often.
    write_cfg(ccdik_pkg::CFG_TOLERANCE, 16'($urandom_range(100, 20000)));
    write_cfg(ccdik_pkg::CFG_MAX_STEPS, 16'($urandom_range(2, 40)));
    gap_pct = 47;
    beats_sent = 0;
    random_part(100);
    drain();

    // Back-to-back commands with fresh settings.
    write_cfg(ccdik_pkg::CFG_TOLERANCE, 16'($urandom_range(1, 65535)));
    write_cfg(ccdik_pkg::CFG_MAX_STEPS, 16'($urandom_range(1, 40)));
    gap_pct = 0;
    beats_sent = 0;
    random_part(100);
    drain();
    repeat (50) @(posedge clk);

    if (arm_sb.mismatches == 0 && arm_sb.limb_expect_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #400000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

### planar_ccd_inverse_kinematics_top.f
design/ccdik_pkg.sv
design/ccdik_cordic.sv
design/planar_ccd_inverse_kinematics_top.sv
tb/tb_top.sv
